>>> rtl/vqbr_pkg.sv
// ----------------------------------------------------------------------------
// vqbr_pkg: shared types and constants of the vq block renderer
// Action codes, codebook geometry, and the command and block records that
// pass between the front, the codebook reader and the row emitter.
// ----------------------------------------------------------------------------
package vqbr_pkg;

  localparam int STRIP_BANKS  = 4;
  localparam int BOOK_ENTRIES = 256;
  localparam int CMDQ_DEPTH   = 2;

  localparam int BANK_W  = (STRIP_BANKS > 1) ? $clog2(STRIP_BANKS) : 1;
  localparam int ENTRY_W = $clog2(BOOK_ENTRIES);
  localparam int COLOR_W = 16;
  localparam int ENT_W   = 4 * COLOR_W;
  localparam int FW_W    = 11;
  localparam int POS_W   = 10;
  localparam int ROW_W   = 11;

  // codebook memory address: {book, bank, entry}
  localparam int RAM_AW    = 1 + BANK_W + ENTRY_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam logic       BOOK_V4 = 1'b0;
  localparam logic       BOOK_V1 = 1'b1;
  localparam logic [2:0] ACT_STRIP = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_V1    = 3'd2;
  localparam logic [2:0] ACT_V4    = 3'd3;
  localparam logic [2:0] ACT_SKIP  = 3'd4;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_V1   = 2'd1,
    CMD_V4   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                book;
    logic [BANK_W-1:0]   bank;
    logic [ENTRY_W-1:0]  entry;
    logic [ENT_W-1:0]    data;
    logic [31:0]         codes;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
  } cmd_t;

  typedef struct packed {
    logic [3:0][ENT_W-1:0] ent;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
  } blk_t;

endpackage

>>> rtl/vqbr_ram.sv
// ----------------------------------------------------------------------------
// vqbr_ram: generic memory, one write port, two registered read ports
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module vqbr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

>>> rtl/vqbr_cmdq.sv
// ----------------------------------------------------------------------------
// vqbr_cmdq: short command queue between front and codebook reader
// Register-based fifo of CMDQ_DEPTH commands.
// ----------------------------------------------------------------------------
module vqbr_cmdq import vqbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t din,
  output logic q_full,
  input  logic rd,
  output logic q_valid,
  output cmd_t head
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rptr_r];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

>>> rtl/vqbr_front.sv
// ----------------------------------------------------------------------------
// vqbr_front: transaction intake, cursor and strip bookkeeping
// Updates the cursor, strip bottom and bank per transaction and queues the
// loads and visible blocks for the back end.
// ----------------------------------------------------------------------------
module vqbr_front import vqbr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [FW_W-1:0]   cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        in_action,
  input  logic [1:0]        in_strip_number,
  input  logic [9:0]        in_strip_height,
  input  logic              in_share_previous,
  input  logic              in_book_select,
  input  logic [7:0]        in_entry_number,
  input  logic [COLOR_W-1:0] in_color_a,
  input  logic [COLOR_W-1:0] in_color_b,
  input  logic [COLOR_W-1:0] in_color_c,
  input  logic [COLOR_W-1:0] in_color_d,
  input  logic [31:0]       in_block_codes,
  output logic              q_push,
  output cmd_t              q_din,
  input  logic              q_full
);

  logic [FW_W-1:0]  frame_width_r, frame_width_nxt;
  logic [POS_W-1:0] col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [ROW_W-1:0] row_limit_r, row_limit_nxt;
  logic [1:0]       active_bank_r, active_bank_nxt;

  logic             accept;
  logic             visible;
  logic             wrap;
  logic [POS_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] row_adv;
  logic [ROW_W-1:0] lim_base;
  logic [ROW_W:0]   lim_sum;
  logic [1:0]       bank_raw;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    frame_width_nxt = cfg_we ? cfg_wdata : frame_width_r;
    col_pos_nxt     = col_pos_r;
    row_pos_nxt     = row_pos_r;
    row_limit_nxt   = row_limit_r;
    active_bank_nxt = active_bank_r;

    // cursor advance
    col_inc = {1'b0, col_pos_r} + (POS_W + 1)'(4);
    wrap    = (col_inc >= frame_width_r) || col_inc[POS_W];
    row_inc = {1'b0, row_pos_r} + (ROW_W + 1)'(4);
    row_adv = row_inc[ROW_W] ? '1 : row_inc[ROW_W-1:0];
    visible = (row_pos_r < row_limit_r);

    // strip start
    lim_base = (in_strip_number == 2'd0) ? '0 : row_limit_r;
    lim_sum  = {1'b0, lim_base} + (ROW_W + 1)'(in_strip_height);
    bank_raw = (in_strip_number != 2'd0 && in_share_previous) ?
               in_strip_number - 2'd1 : in_strip_number;

    q_push       = 1'b0;
    q_din.kind   = CMD_LOAD;
    q_din.book   = in_book_select;
    q_din.bank   = BANK_W'(active_bank_r);
    q_din.entry  = in_entry_number;
    q_din.data   = {in_color_d, in_color_c, in_color_b, in_color_a};
    q_din.codes  = in_block_codes;
    q_din.pos_x  = col_pos_r;
    q_din.pos_y  = row_pos_r[POS_W-1:0];

    if (accept) begin
      unique case (in_action)
        ACT_STRIP: begin
          if (in_strip_number == 2'd0) begin
            row_pos_nxt = '0;
          end
          row_limit_nxt   = lim_sum[ROW_W] ? '1 : lim_sum[ROW_W-1:0];
          col_pos_nxt     = '0;
          active_bank_nxt = 2'((32'(bank_raw)) % STRIP_BANKS);
        end
        ACT_LOAD: begin
          q_push = 1'b1;
        end
        ACT_V1, ACT_V4: begin
          if (visible) begin
            q_push      = 1'b1;
            q_din.kind  = (in_action == ACT_V1) ? CMD_V1 : CMD_V4;
            col_pos_nxt = wrap ? '0 : col_inc[POS_W-1:0];
            row_pos_nxt = wrap ? row_adv : row_pos_r;
          end
        end
        ACT_SKIP: begin
          if (visible) begin
            col_pos_nxt = wrap ? '0 : col_inc[POS_W-1:0];
            row_pos_nxt = wrap ? row_adv : row_pos_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FW_W'(240);
      col_pos_r     <= '0;
      row_pos_r     <= '0;
      row_limit_r   <= '0;
      active_bank_r <= '0;
    end else begin
      frame_width_r <= frame_width_nxt;
      col_pos_r     <= col_pos_nxt;
      row_pos_r     <= row_pos_nxt;
      row_limit_r   <= row_limit_nxt;
      active_bank_r <= active_bank_nxt;
    end
  end

endmodule

>>> rtl/vqbr_back.sv
// ----------------------------------------------------------------------------
// vqbr_back: codebook writer and reader
// Pops queued commands, writes loaded entries, fetches V4 entries two at a
// time or the one V1 entry, and hands the gathered block to the row emitter.
// ----------------------------------------------------------------------------
module vqbr_back import vqbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  output logic blk_valid,
  output blk_t blk,
  input  logic blk_ready
);

  typedef enum logic [2:0] {
    RD_IDLE = 3'b001,
    RD_MID  = 3'b010,
    RD_FIN  = 3'b100
  } rd_state_t;

  rd_state_t         state_r, state_nxt;
  logic              v4_r, v4_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  logic [15:0]       codes_r, codes_nxt;
  logic [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic [ENT_W-1:0]  g0_r, g0_nxt;
  logic [ENT_W-1:0]  g1_r, g1_nxt;

  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] waddr, raddr0, raddr1;
  logic [ENT_W-1:0]  rdata0, rdata1;
  logic [COLOR_W-1:0] ca, cb, cc, cd;

  vqbr_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RAM_DEPTH)
  ) u_books (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (q_head.data),
    .re    (ram_re),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  always_comb begin
    state_nxt = state_r;
    v4_nxt    = v4_r;
    bank_nxt  = bank_r;
    codes_nxt = codes_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    g0_nxt    = g0_r;
    g1_nxt    = g1_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    waddr     = {q_head.book, q_head.bank, q_head.entry};
    raddr0    = {BOOK_V4, q_head.bank, q_head.codes[31:24]};
    raddr1    = {BOOK_V4, q_head.bank, q_head.codes[23:16]};
    blk_valid = 1'b0;

    unique case (state_r)
      RD_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bank_nxt  = q_head.bank;
          codes_nxt = q_head.codes[15:0];
          pos_x_nxt = q_head.pos_x;
          pos_y_nxt = q_head.pos_y;
          unique case (q_head.kind)
            CMD_LOAD: begin
              ram_we = 1'b1;
            end
            CMD_V1: begin
              ram_re    = 1'b1;
              raddr0    = {BOOK_V1, q_head.bank, q_head.codes[31:24]};
              raddr1    = {BOOK_V1, q_head.bank, q_head.codes[31:24]};
              v4_nxt    = 1'b0;
              state_nxt = RD_FIN;
            end
            CMD_V4: begin
              ram_re    = 1'b1;
              v4_nxt    = 1'b1;
              state_nxt = RD_MID;
            end
            default: begin
            end
          endcase
        end
      end
      RD_MID: begin
        // first two entries land, fetch the lower pair
        g0_nxt    = rdata0;
        g1_nxt    = rdata1;
        ram_re    = 1'b1;
        raddr0    = {BOOK_V4, bank_r, codes_r[15:8]};
        raddr1    = {BOOK_V4, bank_r, codes_r[7:0]};
        state_nxt = RD_FIN;
      end
      RD_FIN: begin
        blk_valid = 1'b1;
        if (blk_ready) begin
          state_nxt = RD_IDLE;
        end
      end
      default: begin
        state_nxt = RD_IDLE;
      end
    endcase
  end

  // v1 entries spread to the v4 layout: each quadrant is one flat color
  assign ca = rdata0[COLOR_W-1:0];
  assign cb = rdata0[2*COLOR_W-1:COLOR_W];
  assign cc = rdata0[3*COLOR_W-1:2*COLOR_W];
  assign cd = rdata0[4*COLOR_W-1:3*COLOR_W];

  always_comb begin
    blk.pos_x = pos_x_r;
    blk.pos_y = pos_y_r;
    if (v4_r) begin
      blk.ent[0] = g0_r;
      blk.ent[1] = g1_r;
      blk.ent[2] = rdata0;
      blk.ent[3] = rdata1;
    end else begin
      blk.ent[0] = {4{ca}};
      blk.ent[1] = {4{cb}};
      blk.ent[2] = {4{cc}};
      blk.ent[3] = {4{cd}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v4_r    <= v4_nxt;
    bank_r  <= bank_nxt;
    codes_r <= codes_nxt;
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    g0_r    <= g0_nxt;
    g1_r    <= g1_nxt;
  end

endmodule

>>> rtl/vqbr_rows.sv
// ----------------------------------------------------------------------------
// vqbr_rows: pixel row emitter
// Holds one gathered block and presents its four rows, one per transaction.
// ----------------------------------------------------------------------------
module vqbr_rows import vqbr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               blk_valid,
  input  blk_t               blk,
  output logic               blk_ready,
  output logic               empty,
  input  logic               pop,
  output logic [POS_W-1:0]   out_pos_x,
  output logic [POS_W-1:0]   out_pos_y,
  output logic [COLOR_W-1:0] out_pix0,
  output logic [COLOR_W-1:0] out_pix1,
  output logic [COLOR_W-1:0] out_pix2,
  output logic [COLOR_W-1:0] out_pix3,
  output logic               out_last_row
);

  logic       vld_r, vld_nxt;
  logic [1:0] row_r, row_nxt;
  blk_t       cur_r;
  logic       take, done, load;
  logic [ENT_W-1:0] sel_lo, sel_hi;
  logic [31:0]      w_lo, w_hi;

  assign take      = pop && vld_r;
  assign done      = take && (row_r == 2'd3);
  assign blk_ready = !vld_r || done;
  assign load      = blk_valid && blk_ready;

  always_comb begin
    vld_nxt = vld_r;
    row_nxt = row_r;
    if (load) begin
      vld_nxt = 1'b1;
      row_nxt = 2'd0;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      row_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= blk;
    end
  end

  // upper half of the block from entries 0/1, lower from 2/3
  assign sel_lo = row_r[1] ? cur_r.ent[2] : cur_r.ent[0];
  assign sel_hi = row_r[1] ? cur_r.ent[3] : cur_r.ent[1];
  assign w_lo   = row_r[0] ? sel_lo[63:32] : sel_lo[31:0];
  assign w_hi   = row_r[0] ? sel_hi[63:32] : sel_hi[31:0];

  assign empty        = !vld_r;
  assign out_pos_x    = cur_r.pos_x;
  assign out_pos_y    = cur_r.pos_y + POS_W'(row_r);
  assign out_pix0     = w_lo[15:0];
  assign out_pix1     = w_lo[31:16];
  assign out_pix2     = w_hi[15:0];
  assign out_pix3     = w_hi[31:16];
  assign out_last_row = (row_r == 2'd3);

endmodule

>>> rtl/vq_block_renderer.sv
// ----------------------------------------------------------------------------
// vq_block_renderer: 4x4 vector quantizer block renderer
// Renders blocks from per-strip V1/V4 codebooks into pixel row transactions.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------
//   input     push / full        in_action .. in_block_codes
//   result    empty / pop        out_pos_x, out_pos_y, out_pix0..3, out_last_row
//   config    cfg_we             cfg_wdata (frame width)
//
// front: one input transaction per cycle while the command queue has room;
//   strip starts, skips and hidden blocks end there
// back: loads are written from the queue head; a V1 block is one read and a
//   V4 block two dual-port reads, then hand-off; rows go out one per pop cycle
// reset: synchronous, active low; codebook memory is not cleared
// stalls: the command queue and the emitter's block register decouple the sides
//
module vq_block_renderer import vqbr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [FW_W-1:0]    cfg_wdata,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_action,
  input  logic [1:0]         in_strip_number,
  input  logic [9:0]         in_strip_height,
  input  logic               in_share_previous,
  input  logic               in_book_select,
  input  logic [7:0]         in_entry_number,
  input  logic [COLOR_W-1:0] in_color_a,
  input  logic [COLOR_W-1:0] in_color_b,
  input  logic [COLOR_W-1:0] in_color_c,
  input  logic [COLOR_W-1:0] in_color_d,
  input  logic [31:0]        in_block_codes,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic [POS_W-1:0]   out_pos_x,
  output logic [POS_W-1:0]   out_pos_y,
  output logic [COLOR_W-1:0] out_pix0,
  output logic [COLOR_W-1:0] out_pix1,
  output logic [COLOR_W-1:0] out_pix2,
  output logic [COLOR_W-1:0] out_pix3,
  output logic               out_last_row
);

  // front to queue
  logic q_push;
  cmd_t q_din;
  logic q_full;
  // queue to back end
  logic q_valid;
  logic q_pop;
  cmd_t q_head;
  // gathered block to row emitter
  logic blk_valid;
  logic blk_ready;
  blk_t blk;

  vqbr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_strip_number  (in_strip_number),
    .in_strip_height  (in_strip_height),
    .in_share_previous(in_share_previous),
    .in_book_select   (in_book_select),
    .in_entry_number  (in_entry_number),
    .in_color_a       (in_color_a),
    .in_color_b       (in_color_b),
    .in_color_c       (in_color_c),
    .in_color_d       (in_color_d),
    .in_block_codes   (in_block_codes),
    .q_push           (q_push),
    .q_din            (q_din),
    .q_full           (q_full)
  );

  // short queue of loads and visible blocks, kept in order so a load
  // never overtakes a block that reads the old entry
  vqbr_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_push),
    .din    (q_din),
    .q_full (q_full),
    .rd     (q_pop),
    .q_valid(q_valid),
    .head   (q_head)
  );

  vqbr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .blk_valid(blk_valid),
    .blk      (blk),
    .blk_ready(blk_ready)
  );

  vqbr_rows u_rows (
    .clk         (clk),
    .rst_n       (rst_n),
    .blk_valid   (blk_valid),
    .blk         (blk),
    .blk_ready   (blk_ready),
    .empty       (empty),
    .pop         (pop),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pix0    (out_pix0),
    .out_pix1    (out_pix1),
    .out_pix2    (out_pix2),
    .out_pix3    (out_pix3),
    .out_last_row(out_last_row)
  );

endmodule
